// File: src/assert_macros.svh
// Assertion macros for the RTL, used by shwfu_ctrl. Each reports through $error only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising edge outside reset.
`define SHW_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The expression must never be true at a rising edge outside reset.
`define SHW_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define SHW_ASSERT(lbl, clk, rst, prop, msg)
`define SHW_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

// File: src/shwfu_pkg.sv
`default_nettype none

package shwfu_pkg;

  localparam int WORD_COUNT = 20;

  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 5;
  localparam int VALUE_W = 16;

  localparam logic [BYTE_W-1:0] HDR_SYNC = 8'hFF;
  localparam logic [BYTE_W-1:0] HDR_TAG  = 8'h01;

  localparam int HUNT_POS      = 2;
  localparam int PAYLOAD_START = 4;
  localparam int PAYLOAD_BYTES = 2 * WORD_COUNT;
  localparam int FRAME_BYTES   = PAYLOAD_START + PAYLOAD_BYTES + 1;

  localparam int POS_W   = $clog2(FRAME_BYTES);
  localparam int WADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

  localparam int IN_TDATA_W  = BYTE_W;
  localparam int OUT_FIELD_W = INDEX_W + VALUE_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  typedef struct packed {
    logic take_byte;
    logic rd_en;
    logic word_clr;
    logic word_inc;
  } cmd_t;

  typedef struct packed {
    logic frame_end;
    logic last_word;
  } status_t;

endpackage

`default_nettype wire

// File: src/shwfu_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

module shwfu_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  input  wire shwfu_pkg::status_t status,
  output shwfu_pkg::cmd_t        cmd
);
  import shwfu_pkg::*;

  localparam logic [1:0] ST_RECV = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_SHOW = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    m_tvalid     = 1'b0;
    cmd          = '0;
    case (state)
      ST_RECV: begin
        s_tready      = 1'b1;
        cmd.take_byte = s_tvalid;
        if (s_tvalid && status.frame_end) begin
          cmd.word_clr = 1'b1;
          state_next   = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (status.last_word) begin
            state_next = ST_RECV;
          end else begin
            cmd.word_inc = 1'b1;
            state_next   = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_RECV;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RECV;
    end else begin
      state <= state_next;
    end
  end

  `SHW_NEVER(a_no_overlap, clk, rst, s_tready && m_tvalid, "input taken during burst")
  `SHW_ASSERT(a_burst_starts, clk, rst, (cmd.take_byte && status.frame_end) |=> (!s_tready && !m_tvalid), "frame end did not start burst")
  `SHW_ASSERT(a_burst_ends, clk, rst, (m_tvalid && m_tready && status.last_word) |=> s_tready, "receive not resumed after last word")
  `SHW_ASSERT(a_word_reread, clk, rst, (m_tvalid && m_tready && !status.last_word) |=> (!m_tvalid && !s_tready), "next word shown without a read")

endmodule

`default_nettype wire

// File: src/shwfu_datapath.sv
`default_nettype none

module shwfu_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic [shwfu_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  wire shwfu_pkg::cmd_t                     cmd,
  output logic [shwfu_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic                                     m_tlast,
  output shwfu_pkg::status_t                       status
);
  import shwfu_pkg::*;

  logic [POS_W-1:0]   pos;
  logic [BYTE_W-1:0]  window [2];
  logic [BYTE_W-1:0]  hold;
  logic [WADDR_W-1:0] word_cnt;
  logic [VALUE_W-1:0] rd_data;
  logic [VALUE_W-1:0] mem [WORD_COUNT];

  logic [POS_W-1:0]   off;
  logic               in_payload;
  logic               hdr_match;
  logic               wr_en;
  logic [WADDR_W-1:0] wr_addr;

  assign off        = pos - POS_W'(PAYLOAD_START);
  assign in_payload = (pos >= POS_W'(PAYLOAD_START)) &&
                      (pos < POS_W'(PAYLOAD_START + PAYLOAD_BYTES));
  assign hdr_match  = (window[0] == HDR_SYNC) && (window[1] == HDR_SYNC) &&
                      (s_tdata == HDR_TAG);
  // The second byte of each pair completes a word: the first one waits in hold.
  assign wr_en      = cmd.take_byte && in_payload && off[0];
  assign wr_addr    = off[WADDR_W:1];

  assign status.frame_end = (pos == POS_W'(FRAME_BYTES - 1));
  assign status.last_word = (word_cnt == WADDR_W'(WORD_COUNT - 1));

  assign m_tdata = {{OUT_PAD_W{1'b0}}, rd_data, INDEX_W'(word_cnt)};
  assign m_tlast = status.last_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      window[0] <= '0;
      window[1] <= '0;
    end else if (cmd.take_byte) begin
      if (pos < POS_W'(HUNT_POS)) begin
        window[pos[0]] <= s_tdata;
        pos            <= pos + POS_W'(1);
      end else if (pos == POS_W'(HUNT_POS)) begin
        if (hdr_match) begin
          pos <= pos + POS_W'(1);
        end else begin
          window[0] <= window[1];
          window[1] <= s_tdata;
        end
      end else if (status.frame_end) begin
        pos <= '0;
      end else begin
        pos <= pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && in_payload && !off[0]) begin
      hold <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {hold, s_tdata};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[word_cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_cnt <= '0;
    end else if (cmd.word_clr) begin
      word_cnt <= '0;
    end else if (cmd.word_inc) begin
      word_cnt <= word_cnt + WADDR_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: src/sync_header_word_frame_unpacker.sv
// Takes one received byte per cycle while s_tready is high and hunts for the
// header FF FF 01. After the header it skips one byte, stores 40 payload bytes
// as 20 big-endian words and skips one trailing byte, 45 bytes per frame in
// all. A frame's last byte starts a burst of 20 words on the master side,
// index 0 first and tlast on index 19; during the burst no byte is taken.
// Each word is first read from the word store, then shown until taken, and
// receive resumes in the cycle after the last word is taken.
`default_nettype none

module sync_header_word_frame_unpacker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  // rx_byte[7:0]
  input  wire logic [shwfu_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  // word_index[4:0], word_value[20:5], zero pad [23:21]
  output logic [shwfu_pkg::OUT_TDATA_W-1:0]        m_tdata,
  // last_word
  output logic                                     m_tlast
);
  import shwfu_pkg::*;

  cmd_t    cmd;
  status_t status;

  shwfu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  shwfu_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .cmd     (cmd),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .status  (status)
  );

endmodule

`default_nettype wire

// File: verif/shwfu_word_checker.sv
module shwfu_word_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic [shwfu_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [shwfu_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                              m_tlast,
  output int                                fail_count,
  output int                                words_pending,
  output int                                words_checked,
  output int                                frames_done
);
  timeunit 1ns;
  timeprecision 1ps;
  import shwfu_pkg::*;

  localparam int PIDX_W = $clog2(PAYLOAD_BYTES);

  typedef struct {
    logic [INDEX_W-1:0] index;
    logic [VALUE_W-1:0] value;
    logic               last;
  } frame_word_t;

  frame_word_t       expected_words[$];
  int                frame_pos;
  logic [BYTE_W-1:0] window[2];
  logic [BYTE_W-1:0] payload[PAYLOAD_BYTES];

  // Follows the receiver through hunting and frame capture; on the final byte
  // of a frame the whole payload is queued as words, high byte first.
  task automatic unpack_byte(input logic [BYTE_W-1:0] b);
    frame_word_t w;
    if (frame_pos < HUNT_POS) begin
      window[frame_pos[0]] = b;
      frame_pos++;
    end else if (frame_pos == HUNT_POS) begin
      if (window[0] == HDR_SYNC && window[1] == HDR_SYNC && b == HDR_TAG) begin
        frame_pos++;
      end else begin
        window[0] = window[1];
        window[1] = b;
      end
    end else begin
      if (frame_pos >= PAYLOAD_START && frame_pos < PAYLOAD_START + PAYLOAD_BYTES) begin
        payload[PIDX_W'(frame_pos - PAYLOAD_START)] = b;
      end
      frame_pos++;
      if (frame_pos == FRAME_BYTES) begin
        for (int k = 0; k < WORD_COUNT; k++) begin
          w.index = INDEX_W'(k);
          w.value = {payload[PIDX_W'(2*k)], payload[PIDX_W'(2*k+1)]};
          w.last  = (k == WORD_COUNT - 1);
          expected_words.push_back(w);
        end
        frame_pos = 0;
        frames_done++;
      end
    end
  endtask

  always @(posedge clk) begin
    frame_word_t got;
    frame_word_t want;
    if (rst) begin
      frame_pos = 0;
      window[0] = '0;
      window[1] = '0;
      expected_words.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        unpack_byte(s_tdata);
      end
      if (m_tvalid && m_tready) begin
        got.index = m_tdata[INDEX_W-1:0];
        got.value = m_tdata[INDEX_W +: VALUE_W];
        got.last  = m_tlast;
        words_checked++;
        if (m_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0) begin
          fail_count++;
          $display("%0t: pad bits expected 0, got %b", $time,
                   m_tdata[OUT_TDATA_W-1 -: OUT_PAD_W]);
        end
        if (expected_words.size() == 0) begin
          fail_count++;
          $display("%0t: word expected none, got index %0d value %h last %b", $time,
                   got.index, got.value, got.last);
        end else begin
          want = expected_words.pop_front();
          if (got.index !== want.index) begin
            fail_count++;
            $display("%0t: word_index expected %0d, got %0d", $time, want.index, got.index);
          end
          if (got.value !== want.value) begin
            fail_count++;
            $display("%0t: word_value expected %h, got %h", $time, want.value, got.value);
          end
          if (got.last !== want.last) begin
            fail_count++;
            $display("%0t: last_word expected %b, got %b", $time, want.last, got.last);
          end
        end
      end
    end
    words_pending = expected_words.size();
  end

endmodule

// File: verif/tb_sync_header_word_frame_unpacker.sv
module tb_sync_header_word_frame_unpacker;
  timeunit 1ns;
  timeprecision 1ps;
  import shwfu_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int LONG_HOLD     = 400;
  localparam int RANDOM_BYTES  = 210;
  localparam int EXTREME_BYTES = 10;
  localparam int XIDX_W        = $clog2(EXTREME_BYTES);
  localparam logic [BYTE_W-1:0] EXTREMES[EXTREME_BYTES] =
    '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h80, 8'h00, 8'h55, 8'hAA};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;

  int fail_count;
  int words_pending;
  int words_checked;
  int frames_done;
  int cycles;
  int bytes_sent;
  int burst_left;
  bit hold_req;
  bit hold_done;
  int hold_left;
  int stall_age;
  logic [15:0] stall_pat = '1;

  always #4 clk = ~clk;

  sync_header_word_frame_unpacker uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  shwfu_word_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .fail_count    (fail_count),
    .words_pending (words_pending),
    .words_checked (words_checked),
    .frames_done   (frames_done)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The sink stalls on a rotating pattern that is redrawn now and then, and
  // once during the random part holds off for a long stretch so that the
  // block backs up into its input.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_req && !hold_done && m_tvalid) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
      m_tready <= 1'b0;
    end else begin
      if (stall_age == 0) begin
        stall_pat = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
        stall_age = 48;
      end
      stall_age--;
      stall_pat = {stall_pat[14:0], stall_pat[15]};
      m_tready <= stall_pat[0];
    end
  end

  // Called at a falling edge; returns at the falling edge after the byte is
  // taken, with s_tvalid still high.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  // Noise leans towards the header bytes so that near-misses are common.
  function automatic logic [BYTE_W-1:0] noise_byte();
    case ($urandom_range(7))
      0, 1, 2: return HDR_SYNC;
      3:       return HDR_TAG;
      4:       return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_header();
    send_byte(HDR_SYNC);
    send_byte(HDR_SYNC);
    send_byte(HDR_TAG);
  endtask

  task automatic send_frame_body(input bit extremes);
    send_byte(8'($urandom));
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      if (extremes) begin
        send_byte((k < EXTREME_BYTES) ? EXTREMES[XIDX_W'(k)] : 8'(k * 29));
      end else begin
        send_byte(8'($urandom));
      end
    end
    send_byte(8'($urandom));
  endtask

  task automatic wait_for_words();
    s_tvalid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
  endtask

  initial begin
    int random_start;
    logic [BYTE_W-1:0] b;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // A header in the very first bytes, which fill the window unchecked.
    send_header();
    send_frame_body(1'b1);
    // Near-misses, then an overlapped header FF FF FF FF 01.
    send_byte(8'h01);
    send_byte(HDR_SYNC);
    send_byte(HDR_SYNC);
    send_byte(8'h02);
    send_byte(HDR_SYNC);
    send_byte(HDR_SYNC);
    send_header();
    send_frame_body(1'b0);
    wait_for_words();

    hold_req = 1'b1;
    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      repeat ($urandom_range(6)) send_byte(noise_byte());
      if ($urandom_range(3) == 0) begin
        send_byte(HDR_SYNC);
        if ($urandom_range(1) == 0) begin
          send_byte(HDR_SYNC);
          b = 8'($urandom);
          send_byte((b == HDR_TAG) ? 8'h02 : b);
        end else begin
          send_byte(HDR_TAG);
        end
      end
      send_header();
      send_frame_body(1'b0);
    end
    wait_for_words();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d bytes and checked %0d words from %0d frames, with header near-misses,",
             bytes_sent, words_checked, frames_done);
    $display("gapped and back-to-back input, sink stalls and one long sink hold-off.");
    if (fail_count == 0 && words_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/shwfu_pkg.sv
src/shwfu_ctrl.sv
src/shwfu_datapath.sv
src/sync_header_word_frame_unpacker.sv
verif/shwfu_word_checker.sv
verif/tb_sync_header_word_frame_unpacker.sv
